// ===== hdl/ctid_pkg.sv =====
// ----------------------------------------------------------------------------
// ctid_pkg: camera tamper and idle detector shared definitions
// Beat types, register indexes, alarm codes and reset values of the registers.
// ----------------------------------------------------------------------------
package ctid_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_BRIGHT_LIMIT = 3'd0,
        CFG_BLUR_RATIO   = 3'd1,
        CFG_TAMPER_SCORE = 3'd2,
        CFG_IDLE_LIMIT   = 3'd3,
        CFG_IDLE_SCORE   = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ALARM_BRIGHT = 2'd0,
        ALARM_BLUR   = 2'd1,
        ALARM_COVER  = 2'd2,
        ALARM_IDLE   = 2'd3
    } alarm_kind_t;

    typedef struct packed {
        logic [15:0] brightness;
        logic [31:0] edge_energy;
        logic        baseline_ready;
        logic [15:0] baseline_brightness;
        logic [31:0] baseline_edge_energy;
        logic        scene_idle;
        logic [47:0] now_ms;
    } in_beat_t;

    typedef struct packed {
        alarm_kind_t alarm_kind;
        logic [15:0] alarm_score;
        logic [31:0] idle_duration_ms;
        logic        last_alarm;
    } out_beat_t;

    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [15:0] BRIGHT_LIMIT_RST = 16'd7680;
    localparam logic [15:0] BLUR_RATIO_RST   = 16'd19661;
    localparam logic [15:0] TAMPER_SCORE_RST = 16'd58982;
    localparam logic [31:0] IDLE_LIMIT_RST   = 32'd60000;
    localparam logic [15:0] IDLE_SCORE_RST   = 16'd32768;
    // floor(TAMPER_SCORE_RST * 19 / 20)
    localparam logic [15:0] BLUR_SCORE_RST   = 16'd56032;

    // edge energy at or below this (1e-4 in Q16.16) counts as no edges
    localparam logic [31:0] EDGE_FLOOR = 32'd6;

    // ceil(2^21 / 5): exact reciprocal for dividends below 2^19
    localparam logic [19:0] RECIP5       = 20'd419431;
    localparam int unsigned RECIP5_SHIFT = 21;

endpackage

// ===== hdl/camera_tamper_idle_detector_core.sv =====
// ----------------------------------------------------------------------------
// camera_tamper_idle_detector_core: per-frame tamper and idle alarms
// Checks one frame's statistics and emits its alarms in fixed order.
// ----------------------------------------------------------------------------
// Path: the first alarm of a frame moves through the input register, the
//   alarm set register and the output register in turn, and leaves the
//   output register when the output does not stall.
// Throughput: one frame per cycle when it raises at most one alarm and the
//   output does not stall; with more alarms (up to four) the alarm set
//   register takes the next frame only as the current frame's last alarm moves out.
// Reset: rst_n clears all beats in flight, the previous-frame and idle-timer
//   state, and loads every configuration register with its default value.
// ----------------------------------------------------------------------------
module camera_tamper_idle_detector_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel: one beat per video frame
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ctid_pkg::in_beat_t                in_data,
    // output channel: one beat per alarm
    output logic                              out_valid,
    input  logic                              out_stall,
    output ctid_pkg::out_beat_t               out_data,
    // configuration writes
    input  logic                              cfg_we,
    input  ctid_pkg::cfg_index_t              cfg_index,
    input  logic [ctid_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ctid_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. The blur score (tamper score * 0.95) is
    // worked out when the tamper score is written, so the frame path
    // carries no extra multiplier for it.
    // ------------------------------------------------------------------
    logic [15:0] bright_limit_reg;
    logic [15:0] blur_ratio_reg;
    logic [15:0] tamper_score_reg;
    logic [31:0] idle_limit_reg;
    logic [15:0] idle_score_reg;
    logic [15:0] blur_score_reg;
    logic [15:0] blur_score_next;

    logic [20:0] tamper_x19;
    logic [18:0] tamper_q4;
    logic [39:0] tamper_prod;

    // floor(x*19/20) = floor(floor(x*19/4) / 5), the /5 by reciprocal
    always_comb
    begin
        tamper_x19      = 21'(cfg_data[15:0]) * 21'd19;
        tamper_q4       = tamper_x19[20:2];
        tamper_prod     = 40'(tamper_q4) * 40'(RECIP5);
        blur_score_next = tamper_prod[RECIP5_SHIFT+15:RECIP5_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_limit_reg <= BRIGHT_LIMIT_RST;
            blur_ratio_reg   <= BLUR_RATIO_RST;
            tamper_score_reg <= TAMPER_SCORE_RST;
            idle_limit_reg   <= IDLE_LIMIT_RST;
            idle_score_reg   <= IDLE_SCORE_RST;
            blur_score_reg   <= BLUR_SCORE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BRIGHT_LIMIT: bright_limit_reg <= cfg_data[15:0];
                CFG_BLUR_RATIO:   blur_ratio_reg   <= cfg_data[15:0];
                CFG_TAMPER_SCORE:
                begin
                    tamper_score_reg <= cfg_data[15:0];
                    blur_score_reg   <= blur_score_next;
                end
                CFG_IDLE_LIMIT:   idle_limit_reg   <= cfg_data[31:0];
                CFG_IDLE_SCORE:   idle_score_reg   <= cfg_data[15:0];
                default:          ; // unknown index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic     in_vld_reg;
    in_beat_t in_reg;
    logic     eval_go;     // frame in the input register is evaluated now
    logic     pend_free;   // alarm set register can take a new frame
    logic     in_take;

    assign in_stall = in_vld_reg && !eval_go;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_take || (in_vld_reg && !eval_go);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg <= in_data;
        end
    end

    // ------------------------------------------------------------------
    // Frame state
    // ------------------------------------------------------------------
    logic [15:0] prev_bright_reg;
    logic [31:0] prev_edge_reg;
    logic        prev_vld_reg;
    logic        idle_run_reg;
    logic [47:0] idle_start_reg;
    logic        idle_run_next;
    logic [47:0] idle_start_next;

    // ------------------------------------------------------------------
    // Alarm tests, all on the input register and the frame state
    // ------------------------------------------------------------------
    logic [15:0] base_diff;
    logic [15:0] jump;
    logic [47:0] edge_scaled;
    logic [47:0] blur_limit;
    logic [34:0] edge_x5;
    logic [34:0] prev_edge_x3;
    logic [17:0] jump_x4;
    logic [17:0] limit_x3;
    logic [47:0] idle_dur;
    logic [31:0] idle_dur_sat;
    logic        hit_bright;
    logic        hit_blur;
    logic        hit_cover;
    logic        hit_idle;
    logic [3:0]  new_mask;

    always_comb
    begin
        base_diff = (in_reg.brightness >= in_reg.baseline_brightness)
                  ? in_reg.brightness - in_reg.baseline_brightness
                  : in_reg.baseline_brightness - in_reg.brightness;
        jump      = (in_reg.brightness >= prev_bright_reg)
                  ? in_reg.brightness - prev_bright_reg
                  : prev_bright_reg - in_reg.brightness;

        edge_scaled  = {in_reg.edge_energy, 16'd0};
        blur_limit   = 48'(blur_ratio_reg) * 48'(in_reg.baseline_edge_energy);
        edge_x5      = {in_reg.edge_energy, 2'b00} + 35'(in_reg.edge_energy);
        prev_edge_x3 = {1'b0, prev_edge_reg, 1'b0} + 35'(prev_edge_reg);
        jump_x4      = {jump, 2'b00};
        limit_x3     = {1'b0, bright_limit_reg, 1'b0} + 18'(bright_limit_reg);

        hit_bright = in_reg.baseline_ready && (base_diff >= bright_limit_reg);
        hit_blur   = in_reg.baseline_ready
                  && (in_reg.baseline_edge_energy > EDGE_FLOOR)
                  && (edge_scaled <= blur_limit);
        hit_cover  = prev_vld_reg && (jump_x4 > limit_x3)
                  && (prev_edge_reg > EDGE_FLOOR)
                  && (edge_x5 < prev_edge_x3);

        // idle timer; a timestamp going backwards keeps the period open
        idle_dur        = in_reg.now_ms - idle_start_reg;
        idle_dur_sat    = (idle_dur[47:32] != 16'd0) ? 32'hFFFF_FFFF : idle_dur[31:0];
        hit_idle        = 1'b0;
        idle_run_next   = idle_run_reg;
        idle_start_next = idle_start_reg;
        if (in_reg.scene_idle)
        begin
            if (!idle_run_reg)
            begin
                idle_run_next   = 1'b1;
                idle_start_next = in_reg.now_ms;
            end
            else if (in_reg.now_ms >= idle_start_reg)
            begin
                hit_idle = (idle_dur >= 48'(idle_limit_reg));
            end
        end
        else
        begin
            idle_run_next   = 1'b0;
            idle_start_next = 48'd0;
        end

        new_mask = {hit_idle, hit_cover, hit_blur, hit_bright};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_bright_reg <= 16'd0;
            prev_edge_reg   <= 32'd0;
            prev_vld_reg    <= 1'b0;
            idle_run_reg    <= 1'b0;
            idle_start_reg  <= 48'd0;
        end
        else if (eval_go)
        begin
            prev_bright_reg <= in_reg.brightness;
            prev_edge_reg   <= in_reg.edge_energy;
            prev_vld_reg    <= 1'b1;
            idle_run_reg    <= idle_run_next;
            idle_start_reg  <= idle_start_next;
        end
    end

    // ------------------------------------------------------------------
    // Alarm set register: one bit per alarm kind still to be sent, bit
    // order is send order. Scores come from the configuration, which the user
    // must hold still while frames are in flight; the block does not enforce it.
    // ------------------------------------------------------------------
    logic [3:0]  pend_mask_reg;
    logic [3:0]  pend_mask_next;
    logic [31:0] pend_dur_reg;
    logic [3:0]  pend_low;
    logic [3:0]  pend_rest;
    logic        emit;
    logic        out_vld_reg;
    out_beat_t   out_reg;
    out_beat_t   out_next;

    always_comb
    begin
        pend_low  = pend_mask_reg & (~pend_mask_reg + 4'd1);
        pend_rest = pend_mask_reg & ~pend_low;
        emit      = (pend_mask_reg != 4'd0) && (!out_vld_reg || !out_stall);
        pend_free = (pend_mask_reg == 4'd0) || (emit && (pend_rest == 4'd0));
        eval_go   = in_vld_reg && pend_free;

        if (eval_go)
        begin
            pend_mask_next = new_mask;
        end
        else if (emit)
        begin
            pend_mask_next = pend_rest;
        end
        else
        begin
            pend_mask_next = pend_mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_mask_reg <= 4'd0;
        end
        else
        begin
            pend_mask_reg <= pend_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_go)
        begin
            pend_dur_reg <= idle_dur_sat;
        end
    end

    // ------------------------------------------------------------------
    // Output register: lowest pending alarm goes out first
    // ------------------------------------------------------------------
    always_comb
    begin
        out_next.idle_duration_ms = 32'd0;
        out_next.last_alarm       = (pend_rest == 4'd0);
        case (pend_low)
            4'b0001:
            begin
                out_next.alarm_kind  = ALARM_BRIGHT;
                out_next.alarm_score = tamper_score_reg;
            end
            4'b0010:
            begin
                out_next.alarm_kind  = ALARM_BLUR;
                out_next.alarm_score = blur_score_reg;
            end
            4'b0100:
            begin
                out_next.alarm_kind  = ALARM_COVER;
                out_next.alarm_score = tamper_score_reg;
            end
            4'b1000:
            begin
                out_next.alarm_kind       = ALARM_IDLE;
                out_next.alarm_score      = idle_score_reg;
                out_next.idle_duration_ms = pend_dur_reg;
            end
            default:
            begin
                out_next.alarm_kind  = ALARM_BRIGHT;
                out_next.alarm_score = tamper_score_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= emit || (out_vld_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a pending alarm with room downstream shows up as an output beat
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_vld_reg)
        else $error("pending alarm did not reach the output register");

    // only the idle alarm carries a duration
    a_dur_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_reg.alarm_kind != ALARM_IDLE))
            |-> (out_reg.idle_duration_ms == 32'd0))
        else $error("duration on a non-idle alarm");

    // a beat that is not the frame's last leaves alarms of the same frame pending
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_reg.last_alarm) |-> (pend_mask_reg != 4'd0))
        else $error("frame alarms lost before the last beat");

    // a frame is never taken while earlier alarms still wait
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (eval_go && !emit) |-> (pend_mask_reg == 4'd0))
        else $error("alarm set overwritten");

endmodule

// ===== tb/camera_tamper_idle_detector_core_tb.sv =====
// ----------------------------------------------------------------------------
// camera_tamper_idle_detector_core_tb: self-checking bench for the tamper core
// Drives frame-statistics beats through the valid/stall input channel and
// predicts every alarm beat with a behavioral model of the four tests. Each
// alarm leaving the core is checked field by field against the oldest
// prediction. Register sets run from reset values through both extremes to
// random ones. Both channels idle in random bursts, and one long output
// hold-off backs the core up into its input.
// ----------------------------------------------------------------------------
module camera_tamper_idle_detector_core_tb;

    import ctid_pkg::*;

    localparam int CLK_HIGH       = 4;
    localparam int CLK_LOW        = 4;
    localparam int RESET_CYCLES   = 8;
    // three register stages plus margin; also covers frames that raise nothing
    localparam int SETTLE_CYCLES  = 10;
    // longest stretch with no beat moving on either channel or config port
    localparam int WATCHDOG_LIMIT = 2000;
    // long output hold-off used to fill the core and stall its input
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_BURST      = 18;

    // blur alarm score is the tamper score times 0.95, floored
    localparam int BLUR_NUM = 19;
    localparam int BLUR_DEN = 20;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    in_beat_t                in_data   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    out_beat_t               out_data;
    logic                    cfg_we    = 1'b0;
    cfg_index_t              cfg_index = CFG_BRIGHT_LIMIT;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    always
    begin
        #CLK_HIGH clk = 1'b1;
        #CLK_LOW  clk = 1'b0;
    end

    camera_tamper_idle_detector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the registers, as the core holds them after each write
    // ------------------------------------------------------------------
    logic [15:0] lim_bright = BRIGHT_LIMIT_RST;
    logic [15:0] blur_ratio = BLUR_RATIO_RST;
    logic [15:0] tamper_sc  = TAMPER_SCORE_RST;
    logic [31:0] idle_lim   = IDLE_LIMIT_RST;
    logic [15:0] idle_sc    = IDLE_SCORE_RST;

    // previous-frame memory and idle timer of the alarm predictor
    logic [15:0] prev_br     = '0;
    logic [31:0] prev_edge   = '0;
    bit          prev_seen   = 1'b0;
    bit          idle_timing = 1'b0;
    logic [47:0] idle_t0     = '0;

    // alarms of the frame being predicted, then all alarms still owed
    out_beat_t   frame_alarms[$];
    out_beat_t   pending_alarms[$];
    out_beat_t   oldest_alarm;

    // running state of the random frame source
    logic [15:0] gen_br   = '0;
    logic [31:0] gen_edge = '0;
    bit          gen_idle = 1'b0;
    logic [47:0] gen_now  = '0;

    int errors        = 0;
    int frames_sent   = 0;
    int alarms_seen   = 0;
    int random_sets   = 0;
    int holds_done    = 0;
    int kind_seen[4]  = '{0, 0, 0, 0};

    // receiver idling and the long hold-off request
    bit idling_on   = 1'b1;
    bit hold_go     = 1'b0;
    bit hold_ack    = 1'b0;
    int hold_left   = 0;
    int stall_left  = 0;
    int quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Alarm predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] gap16(input logic [15:0] a, input logic [15:0] b);
        return (a >= b) ? 64'(a - b) : 64'(b - a);
    endfunction

    function automatic void add_alarm(input alarm_kind_t k, input logic [15:0] score,
                                      input logic [31:0] dur);
        out_beat_t a;
        a.alarm_kind       = k;
        a.alarm_score      = score;
        a.idle_duration_ms = dur;
        a.last_alarm       = 1'b0;
        frame_alarms.insert(frame_alarms.size(), a);
    endfunction

    // Works out the alarms one accepted frame causes, in the order the core
    // emits them, and appends them to the pending list.
    task automatic predict_alarms(input in_beat_t f);
        logic [63:0] jump;
        logic [63:0] dur;
        out_beat_t   tail;
        frame_alarms.delete();
        if (f.baseline_ready)
        begin
            if (gap16(f.brightness, f.baseline_brightness) >= 64'(lim_bright))
                add_alarm(ALARM_BRIGHT, tamper_sc, '0);
            // blur: edge / baseline <= ratio, cross-multiplied in Q0.16
            if (f.baseline_edge_energy > EDGE_FLOOR &&
                (64'(f.edge_energy) << 16) <= 64'(blur_ratio) * 64'(f.baseline_edge_energy))
                add_alarm(ALARM_BLUR, 16'((64'(tamper_sc) * BLUR_NUM) / BLUR_DEN), '0);
        end
        if (prev_seen)
        begin
            // cover: jump above 0.75 of the limit and edges below 0.6 of last frame
            jump = gap16(f.brightness, prev_br);
            if (jump * 4 > 64'(lim_bright) * 3 && prev_edge > EDGE_FLOOR &&
                64'(f.edge_energy) * 5 < 64'(prev_edge) * 3)
                add_alarm(ALARM_COVER, tamper_sc, '0);
        end
        prev_br   = f.brightness;
        prev_edge = f.edge_energy;
        prev_seen = 1'b1;
        if (f.scene_idle)
        begin
            if (!idle_timing)
            begin
                idle_timing = 1'b1;
                idle_t0     = f.now_ms;
            end
            else if (f.now_ms >= idle_t0)
            begin
                // clock running backwards gives no alarm and keeps the period
                dur = 64'(f.now_ms - idle_t0);
                if (dur >= 64'(idle_lim))
                    add_alarm(ALARM_IDLE, idle_sc,
                              (dur > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dur[31:0]);
            end
        end
        else
        begin
            idle_timing = 1'b0;
            idle_t0     = '0;
        end
        if (frame_alarms.size() > 0)
        begin
            tail = frame_alarms.pop_back();
            tail.last_alarm = 1'b1;
            frame_alarms.insert(frame_alarms.size(), tail);
        end
        foreach (frame_alarms[i])
            pending_alarms.insert(pending_alarms.size(), frame_alarms[i]);
    endtask

    // ------------------------------------------------------------------
    // Input side: one frame beat per call, with an optional idle burst first.
    // Valid stays up between back-to-back beats and is raised without regard to stall.
    // ------------------------------------------------------------------
    task automatic send_frame(input in_beat_t f);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        do
            @(posedge clk);
        while (in_stall);
        predict_alarms(f);
        frames_sent++;
    endtask

    // Drops valid, waits until every owed alarm has come out, then lets frames
    // that raise nothing run out of the pipeline before a register write.
    task automatic drain;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_alarms.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    // Leaves the write enable up; release_cfg lowers it after a batch.
    task automatic write_reg(input cfg_index_t idx, input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        case (idx)
            CFG_BRIGHT_LIMIT: lim_bright = v[15:0];
            CFG_BLUR_RATIO:   blur_ratio = v[15:0];
            CFG_TAMPER_SCORE: tamper_sc  = v[15:0];
            CFG_IDLE_LIMIT:   idle_lim   = v;
            CFG_IDLE_SCORE:   idle_sc    = v[15:0];
            default: ;  // unmapped index, the core ignores it
        endcase
    endtask

    task automatic release_cfg;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [31:0] br_lim, input logic [31:0] ratio,
                                input logic [31:0] t_score, input logic [31:0] i_lim,
                                input logic [31:0] i_score);
        write_reg(CFG_BRIGHT_LIMIT, br_lim);
        write_reg(CFG_BLUR_RATIO, ratio);
        write_reg(CFG_TAMPER_SCORE, t_score);
        write_reg(CFG_IDLE_LIMIT, i_lim);
        write_reg(CFG_IDLE_SCORE, i_score);
        release_cfg();
    endtask

    // Random set; upper bits of the 16-bit registers carry junk on purpose.
    task automatic random_config;
        logic [31:0] i_lim;
        i_lim = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200000);
        apply_config({16'($urandom), 16'($urandom_range(0, 16'h4000))}, $urandom,
                     $urandom, i_lim, $urandom);
        random_sets++;
    endtask

    // ------------------------------------------------------------------
    // Frame sources
    // ------------------------------------------------------------------
    function automatic in_beat_t mk_frame(input logic [15:0] br, input logic [31:0] edge_e,
                                          input bit rdy, input logic [15:0] base_br,
                                          input logic [31:0] base_edge, input bit idl,
                                          input logic [47:0] now);
        in_beat_t f;
        f.brightness           = br;
        f.edge_energy          = edge_e;
        f.baseline_ready       = rdy;
        f.baseline_brightness  = base_br;
        f.baseline_edge_energy = base_edge;
        f.scene_idle           = idl;
        f.now_ms               = now;
        return f;
    endfunction

    // value within about r either side of zero, modulo 2^16
    function automatic logic [15:0] jitter(input logic [15:0] r);
        return 16'($urandom_range(0, 2 * r + 2) - r - 1);
    endfunction

    // Mostly coherent frames: brightness near the baseline or the last frame,
    // edges scaled from the baseline or the last frame, idle in runs, and a
    // clock that steps forward at the pace of the idle limit. The rest is
    // raw noise, time jumping back, and very long idle stretches.
    function automatic in_beat_t random_frame();
        in_beat_t    f;
        logic [31:0] span;
        f.baseline_ready      = ($urandom_range(0, 3) != 0);
        f.baseline_brightness = 16'($urandom);
        case ($urandom_range(0, 2))
            0:       f.brightness = 16'($urandom);
            1:       f.brightness = f.baseline_brightness + jitter(lim_bright);
            default: f.brightness = gen_br + jitter(lim_bright);
        endcase
        case ($urandom_range(0, 3))
            0:       f.baseline_edge_energy = $urandom_range(0, 10);
            1:       f.baseline_edge_energy = $urandom >> $urandom_range(0, 31);
            default: f.baseline_edge_energy = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: f.edge_energy = $urandom;
            1: f.edge_energy = 32'((64'(f.baseline_edge_energy) *
                                    $urandom_range(0, 2 * blur_ratio + 2)) >> 16);
            2: f.edge_energy = 32'((64'(gen_edge) * $urandom_range(0, 8)) >> 3);
            default: f.edge_energy = $urandom_range(0, 10);
        endcase
        if ($urandom_range(0, 5) == 0)
            gen_idle = !gen_idle;
        f.scene_idle = gen_idle;
        span = idle_lim / 3 + 16;
        case ($urandom_range(0, 19))
            0:       gen_now = {16'($urandom), 32'($urandom)};
            1:       gen_now = gen_now - 48'($urandom_range(0, span));
            2:       gen_now = gen_now + {16'($urandom_range(0, 255)), 32'($urandom)};
            default: gen_now = gen_now + 48'($urandom_range(0, span));
        endcase
        f.now_ms = gen_now;
        gen_br   = f.brightness;
        gen_edge = f.edge_energy;
        return f;
    endfunction

    task automatic run_random(input int n);
        in_beat_t f;
        repeat (n)
        begin
            f = random_frame();
            send_frame(f);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall bursts, plus the long hold-off, counted here
    // and started by a toggle of hold_go.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_go != hold_ack)
        begin
            hold_ack   <= hold_go;
            hold_left  <= HOLD_CYCLES - 1;
            holds_done <= holds_done + 1;
            out_stall  <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, MAX_BURST - 1);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Alarm checker: every accepted output beat against the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        errors++;
        $display("%0t: alarm %0d %s: expected 0x%0h, got 0x%0h",
                 $realtime, alarms_seen, what, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_alarms.size() == 0)
                report_mismatch("beat with no alarm owed", '0, 64'(out_data));
            else
            begin
                oldest_alarm = pending_alarms.pop_front();
                if (out_data.alarm_kind !== oldest_alarm.alarm_kind)
                    report_mismatch("alarm_kind", 64'(oldest_alarm.alarm_kind),
                                    64'(out_data.alarm_kind));
                if (out_data.alarm_score !== oldest_alarm.alarm_score)
                    report_mismatch("alarm_score", 64'(oldest_alarm.alarm_score),
                                    64'(out_data.alarm_score));
                if (out_data.idle_duration_ms !== oldest_alarm.idle_duration_ms)
                    report_mismatch("idle_duration_ms", 64'(oldest_alarm.idle_duration_ms),
                                    64'(out_data.idle_duration_ms));
                if (out_data.last_alarm !== oldest_alarm.last_alarm)
                    report_mismatch("last_alarm", 64'(oldest_alarm.last_alarm),
                                    64'(out_data.last_alarm));
                kind_seen[oldest_alarm.alarm_kind]++;
            end
            alarms_seen++;
        end
    end

    // Watchdog: ends the run if no beat moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("** camera_tamper_idle_detector_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values; field extremes, every alarm kind, the exact
    // threshold edges and each corner of the edge and idle logic.
    task automatic test_directed;
        // first frame: no previous frame, nothing ready, nothing idle
        send_frame(mk_frame('0, '0, 1'b0, '0, '0, 1'b0, '0));
        // all ones: brightness shift; previous edge energy is zero so no cover;
        // idle period starts at the top of the clock
        send_frame(mk_frame('1, '1, 1'b1, '0, '1, 1'b1, '1));
        // blur against a baseline just over the floor, cover, and time going
        // backwards while idle (no alarm, period keeps running)
        send_frame(mk_frame('0, '0, 1'b1, '0, 32'd7, 1'b1, 48'd5));
        // baseline edge energy at the floor: no blur test; idle period ends
        send_frame(mk_frame('0, '0, 1'b1, '0, 32'd6, 1'b0, 48'd6));
        // brightness exactly at the limit, blur ratio exactly met; idle starts
        send_frame(mk_frame(16'd7680, 32'd19661, 1'b1, '0, 32'd65536, 1'b1, 48'd1000));
        // one below the limit, one over the ratio; idle one ms short
        send_frame(mk_frame(16'd15359, 32'd19662, 1'b1, 16'd7680, 32'd65536,
                            1'b1, 48'd60999));
        // jump exactly 0.75 of the limit: no cover; idle limit reached exactly
        send_frame(mk_frame(16'd21119, 32'd1000, 1'b0, '0, '0, 1'b1, 48'd61000));
        // edge drop exactly 0.6: no cover; idle beyond 32 bits saturates
        send_frame(mk_frame(16'd26880, 32'd600, 1'b0, '0, '0, 1'b1, 48'h1_0000_03ED));
        // jump one over 0.75 and a real drop: cover plus a long idle alarm
        send_frame(mk_frame(16'd32641, 32'd359, 1'b0, '0, '0, 1'b1, 48'h100_0000_03E8));
        // all four alarms from one frame
        send_frame(mk_frame('0, '0, 1'b1, 16'h8000, 32'h0010_0000, 1'b1,
                            48'h200_0000_0000));
        send_frame(mk_frame(16'h1234, 32'hFFFF_0000, 1'b1, 16'h1200, 32'h0000_FFFF,
                            1'b0, 48'h200_0000_0001));
        // idle from time zero to the end of the clock: widest duration
        send_frame(mk_frame('1, '0, 1'b1, '1, '1, 1'b1, '0));
        send_frame(mk_frame('1, '1, 1'b0, '1, '1, 1'b1, '1));
        drain();
    endtask

    // Both extreme register sets, then writes to unmapped indexes.
    task automatic test_config_extremes;
        int i;
        apply_config('0, '0, '0, '0, '0);
        run_random(35);
        drain();
        apply_config('1, '1, '1, '1, '1);
        run_random(35);
        drain();
        for (i = int'(CFG_IDLE_SCORE) + 1; i < (1 << $bits(cfg_index_t)); i++)
            write_reg(cfg_index_t'(i), $urandom);
        release_cfg();
        run_random(30);
        drain();
        apply_config(BRIGHT_LIMIT_RST, BLUR_RATIO_RST, TAMPER_SCORE_RST, IDLE_LIMIT_RST,
                     IDLE_SCORE_RST);
    endtask

    // Bulk random frames across several random register sets, with idling
    // switched off for some stretches.
    task automatic test_random_sweep;
        repeat (6)
        begin
            random_config();
            idling_on = ($urandom_range(0, 3) != 0);
            run_random(50);
            drain();
        end
        idling_on = 1'b1;
    endtask

    // Output held off for a long stretch while frames keep coming; a zero
    // brightness limit and idle limit make most frames raise several alarms.
    task automatic test_output_hold;
        apply_config('0, 32'hFFFF, $urandom, '0, $urandom);
        hold_go <= ~hold_go;
        run_random(30);
        drain();
    endtask

    // Last stretch with no idling on either side.
    task automatic test_quiet_tail;
        idling_on = 1'b0;
        random_config();
        run_random(30);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_random_sweep();
        test_output_hold();
        test_quiet_tail();

        $display("covered %0d frames, %0d alarms (shift %0d, blur %0d, cover %0d, idle %0d)",
                 frames_sent, alarms_seen, kind_seen[ALARM_BRIGHT], kind_seen[ALARM_BLUR],
                 kind_seen[ALARM_COVER], kind_seen[ALARM_IDLE]);
        $display("register sets: reset, all zero, all ones, %0d random; %0d long hold-off(s)",
                 random_sets, holds_done);
        if (errors == 0)
            $display("** camera_tamper_idle_detector_core: PASSED **");
        else
            $display("** camera_tamper_idle_detector_core: FAILED **");
        $finish;
    end

endmodule

// ===== camera_tamper_idle_detector_core.f =====
hdl/ctid_pkg.sv
hdl/camera_tamper_idle_detector_core.sv
tb/camera_tamper_idle_detector_core_tb.sv
